@@ hw/rtl/ntc_pkg.sv @@
// ----------------------------------------------------------------------------
// ntc_pkg
// shared types and constants for the ntc beta thermometer
// ----------------------------------------------------------------------------
package ntc_pkg;

  localparam int unsigned FracBits = 24;
  localparam logic [29:0] Ln2Q30 = 30'd744261118;
  localparam int ZeroCCentiK = 27315;

  localparam logic [1:0] STATUS_REPORTED = 2'd0;
  localparam logic [1:0] STATUS_SMALL    = 2'd1;
  localparam logic [1:0] STATUS_INVALID  = 2'd2;

  localparam logic [2:0] REG_SUPPLY  = 3'd0;
  localparam logic [2:0] REG_FIXED   = 3'd1;
  localparam logic [2:0] REG_NOMR    = 3'd2;
  localparam logic [2:0] REG_NOMT    = 3'd3;
  localparam logic [2:0] REG_BETA    = 3'd4;
  localparam logic [2:0] REG_DELTA   = 3'd5;

  typedef enum logic [2:0] {
    DIV_IDLE,
    DIV_RUN
  } div_state_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RDIV,
    ST_RWAIT,
    ST_LOGN,
    ST_LOGD,
    ST_LN,
    ST_DEN,
    ST_TDIV,
    ST_TWAIT,
    ST_OUT
  } ntc_state_t;

endpackage

@@ hw/rtl/ntc_beta_thermometer.sv @@
// ----------------------------------------------------------------------------
// ntc_beta_thermometer
// ntc thermistor resistance and beta equation temperature, one item at a time
// ----------------------------------------------------------------------------
// One valid item runs from acceptance to result through a restoring divide
// for the resistance, two log2 runs (up to 63 normalize shifts, 24 squarings
// and handshake each), the ln and denominator steps and a second divide for
// the temperature; the log runs are shorter the larger their arguments. An
// invalid item gives its result in the cycle after acceptance. stall is high
// while an item is in work and while a result waits to be taken.
module ntc_beta_thermometer #(
  parameter int VOLTAGE_WIDTH = 12
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [VOLTAGE_WIDTH-1:0] voltage_mv,
  input  logic                     calibrated,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               status,
  output logic signed [15:0]       temperature_centi_c,
  output logic [23:0]              resistance_ohm,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [4:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import ntc_pkg::*;

  logic [11:0]        supply_mv;
  logic [19:0]        fixed_ohm;
  logic [19:0]        nom_ohm;
  logic signed [14:0] nom_t;
  logic [13:0]        beta;
  logic [13:0]        delta;
  logic signed [15:0] last_rep;
  logic               rep_once;

  ntc_state_t state, state_next;

  logic [VOLTAGE_WIDTH-1:0] v;
  logic [15:0]  vdiff;
  logic [63:0]  numr, denr;
  logic [29:0]  lnum;
  logic signed [31:0] d;
  logic [31:0]  mag;
  logic [61:0]  magp;
  logic signed [31:0] lnq;
  logic signed [63:0] den, num;
  logic signed [63:0] den_c;
  logic [23:0]  res;
  logic signed [15:0] tmp;
  logic         zero_r;

  logic         div_start, div_done;
  logic [63:0]  div_a, div_b, div_q;
  logic         log_start, log_done;
  logic [63:0]  log_x;
  logic [29:0]  log_r;

  logic [2:0] ridx;
  assign ridx = paddr[4:2];
  assign pready = 1'b1;

  always_comb begin
    case (ridx)
      REG_SUPPLY: prdata = {20'd0, supply_mv};
      REG_FIXED:  prdata = {12'd0, fixed_ohm};
      REG_NOMR:   prdata = {12'd0, nom_ohm};
      REG_NOMT:   prdata = {17'd0, nom_t};
      REG_BETA:   prdata = {18'd0, beta};
      REG_DELTA:  prdata = {18'd0, delta};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      supply_mv <= 12'd3300;
      fixed_ohm <= 20'd1000;
      nom_ohm   <= 20'd10000;
      nom_t     <= 15'sd2500;
      beta      <= 14'd3950;
      delta     <= 14'd50;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_SUPPLY: supply_mv <= pwdata[11:0];
        REG_FIXED:  fixed_ohm <= pwdata[19:0];
        REG_NOMR:   nom_ohm   <= pwdata[19:0];
        REG_NOMT:   nom_t     <= pwdata[14:0];
        REG_BETA:   beta      <= pwdata[13:0];
        REG_DELTA:  delta     <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  ntc_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(div_q)
  );

  ntc_log u_log (
    .clk(clk), .rst(rst), .start(log_start), .x(log_x), .done(log_done),
    .result(log_r)
  );

  logic signed [16:0] t0ck;
  logic [20:0]  bk100;
  logic signed [63:0] tq;
  logic signed [63:0] absdiff;
  logic bad;

  assign t0ck  = 17'(nom_t) + 17'sd27315;
  assign bk100 = 21'(beta) * 21'd100;
  assign vdiff = 16'(supply_mv) - 16'(v);
  assign bad = !calibrated || voltage_mv == '0
               || 16'(voltage_mv) >= 16'(supply_mv);
  assign magp = mag[31:0] * Ln2Q30;
  assign den_c = $signed(64'(bk100) << FracBits) + 64'(t0ck) * 64'(lnq);
  assign in_stall = state != ST_IDLE || out_valid;

  always_comb begin
    state_next = state;
    div_start = 1'b0;
    log_start = 1'b0;
    div_a = numr + 64'(vdiff[15:1]);
    div_b = 64'(vdiff);
    log_x = numr;
    case (state)
      ST_IDLE: if (in_valid && !out_valid && !bad) state_next = ST_RDIV;
      ST_RDIV: begin
        div_start = 1'b1;
        state_next = ST_RWAIT;
      end
      ST_RWAIT: if (div_done) begin
        if (zero_r) state_next = ST_OUT;
        else begin
          log_start = 1'b1;
          state_next = ST_LOGN;
        end
      end
      ST_LOGN: if (log_done) begin
        log_x = denr;
        log_start = 1'b1;
        state_next = ST_LOGD;
      end
      ST_LOGD: if (log_done) state_next = ST_LN;
      ST_LN: state_next = ST_DEN;
      ST_DEN: state_next = (den_c <= 0) ? ST_OUT : ST_TDIV;
      ST_TDIV: begin
        div_a = 64'(num + (den >>> 1));
        div_b = 64'(den);
        div_start = 1'b1;
        state_next = ST_TWAIT;
      end
      ST_TWAIT: if (div_done) state_next = ST_OUT;
      ST_OUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign tq = $signed(div_q) - 64'sd27315;
  assign absdiff = (64'(tmp) - 64'(last_rep) < 0) ? 64'(last_rep) - 64'(tmp)
                                                   : 64'(tmp) - 64'(last_rep);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      last_rep  <= '0;
      rep_once  <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (state == ST_IDLE && in_valid && !out_valid && bad) begin
        out_valid <= 1'b1;
        status <= STATUS_INVALID;
        temperature_centi_c <= '0;
        resistance_ohm <= '0;
      end
      if (state == ST_OUT) begin
        out_valid <= 1'b1;
        temperature_centi_c <= tmp;
        resistance_ohm <= res;
        if (!rep_once || absdiff > 64'(delta)) begin
          status <= STATUS_REPORTED;
          last_rep <= tmp;
          rep_once <= 1'b1;
        end else status <= STATUS_SMALL;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        v <= voltage_mv;
        numr <= 64'(fixed_ohm) * 64'(voltage_mv);
        denr <= 64'(nom_ohm) * 64'(16'(supply_mv) - 16'(voltage_mv));
        zero_r <= fixed_ohm == '0 || nom_ohm == '0;
      end
      ST_RWAIT: if (div_done) begin
        res <= (div_q > 64'hFFFFFF) ? 24'hFFFFFF : div_q[23:0];
        if (zero_r) tmp <= -16'sd27315;
      end
      ST_LOGN: if (log_done) lnum <= log_r;
      ST_LOGD: if (log_done) begin
        d   <= $signed({2'b0, lnum}) - $signed({2'b0, log_r});
        mag <= ($signed({2'b0, lnum}) < $signed({2'b0, log_r}))
               ? 32'(log_r - lnum) : 32'(lnum - log_r);
      end
      ST_LN: begin
        lnq <= (d < 0) ? -$signed(32'((magp + 62'h20000000) >> 30))
                       : $signed(32'((magp + 62'h20000000) >> 30));
      end
      ST_DEN: begin
        den <= den_c;
        num <= (64'(bk100) * 64'(t0ck)) <<< FracBits;
        if (den_c <= 0)
          tmp <= 16'sd32767;
      end
      ST_TWAIT: if (div_done) begin
        if (tq > 64'sd32767) tmp <= 16'sd32767;
        else if (tq < -64'sd32768) tmp <= -16'sd32768;
        else tmp <= tq[15:0];
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall) else $error("busy without stall");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) |=> out_valid) else $error("result lost");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("stalled result dropped");

endmodule

@@ hw/rtl/ntc_div.sv @@
// ----------------------------------------------------------------------------
// ntc_div
// restoring divider, one quotient bit per cycle, 64 bit unsigned
// ----------------------------------------------------------------------------
module ntc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);
  import ntc_pkg::*;

  div_state_t state, state_next;
  logic [6:0]   count;
  logic [63:0]  quo;
  logic [64:0]  rem;
  logic [63:0]  dsr;
  logic [64:0]  trial;

  assign trial = {rem[63:0], quo[63]};
  assign quotient = quo;

  always_comb begin
    state_next = state;
    done = 1'b0;
    case (state)
      DIV_IDLE: if (start) state_next = DIV_RUN;
      DIV_RUN: if (count == 7'd64) begin
        state_next = DIV_IDLE;
        done = 1'b1;
      end
      default: state_next = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == DIV_IDLE) count <= '0;
      else if (count != 7'd64) count <= count + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == DIV_IDLE && start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (state == DIV_RUN && count != 7'd64) begin
      if (trial >= {1'b0, dsr}) begin
        rem <= trial - {1'b0, dsr};
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[62:0], 1'b0};
      end
    end
  end

endmodule

@@ hw/rtl/ntc_log.sv @@
// ----------------------------------------------------------------------------
// ntc_log
// log2 in q24, msb search then one squaring per fraction bit
// ----------------------------------------------------------------------------
module ntc_log (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] x,
  output logic        done,
  output logic [29:0] result
);
  import ntc_pkg::*;

  logic        busy;
  logic        norm;
  logic        fin;
  logic [5:0]  p;
  logic [4:0]  bitn;
  logic [63:0] xs;
  logic [31:0] m;
  logic [63:0] sq;
  logic [33:0] sqs;
  logic [29:0] acc;

  assign sq = m * m;
  assign sqs = sq[63:30];
  assign result = acc;
  assign done = fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (start) busy <= 1'b1;
      else if (busy && !norm && bitn == 5'd0) begin
        busy <= 1'b0;
        fin  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xs   <= x;
      p    <= 6'd63;
      norm <= 1'b1;
      bitn <= 5'd24;
    end else if (busy && norm) begin
      if (xs[63] || p == 6'd0) begin
        norm <= 1'b0;
        m    <= {1'b0, xs[63:33]};
        acc  <= {p, 24'd0};
      end else begin
        xs <= {xs[62:0], 1'b0};
        p  <= p - 6'd1;
      end
    end else if (busy && bitn != 5'd0) begin
      bitn <= bitn - 5'd1;
      if (sqs[31]) begin
        m <= sqs[32:1];
        acc[bitn - 5'd1] <= 1'b1;
      end else begin
        m <= sqs[31:0];
      end
    end
  end

endmodule

@@ test/ntc_beta_thermometer_tb.sv @@
// ----------------------------------------------------------------------------
// ntc_beta_thermometer_tb
// self-checking bench: a fixed-point beta equation predictor checks every
// reading, with random gaps and stalls on both sides and register phases
// that range from the extremes to random thermistor settings
// ----------------------------------------------------------------------------
module ntc_beta_thermometer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ntc_pkg::*;

  typedef struct {
    logic [11:0] volt;
    logic        cal;
  } sample_t;

  typedef struct {
    logic [1:0]         stat;
    logic signed [15:0] temp;
    logic [23:0]        res;
  } reading_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [11:0] voltage_mv = '0;
  logic calibrated = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [1:0] status;
  logic signed [15:0] temperature_centi_c;
  logic [23:0] resistance_ohm;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ntc_beta_thermometer dut (.*);

  always #2 clk = ~clk;

  longint unsigned cfg_supply, cfg_fixed, cfg_nomr, cfg_beta, cfg_delta;
  longint          cfg_nomt;
  logic signed [15:0] last_temp;
  logic               reported;

  sample_t  samples_q[$];
  reading_t readings_q[$];
  int  mismatches = 0;
  bit  in_took = 0;
  bit  idle_on = 1;
  bit  hold_tx = 0;
  int  tx_gap = 0, rx_gap = 0;
  int  rx_hold = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic longint log2_q24(longint unsigned x);
    int p;
    longint unsigned m;
    longint acc;
    p = 63;
    while (p > 0 && x[p] == 1'b0) p--;
    if (p > 30) m = x >> (p - 30);
    else m = x << (30 - p);
    acc = longint'(p) << FracBits;
    for (int i = FracBits - 1; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m >>= 1;
        acc += longint'(1) << i;
      end
    end
    return acc;
  endfunction

  function automatic logic signed [15:0] clamp16(longint t);
    if (t > 32767) return 16'sd32767;
    if (t < -32768) return -16'sd32768;
    return t[15:0];
  endfunction

  function automatic logic signed [15:0] beta_temp(longint unsigned v);
    longint unsigned num_r, den_r, mag;
    longint d, ln_q24, t0ck, num, den;
    num_r = cfg_fixed * v;
    den_r = cfg_nomr * (cfg_supply - v);
    if (num_r == 0 || den_r == 0) return clamp16(-ZeroCCentiK);
    d = log2_q24(num_r) - log2_q24(den_r);
    mag = d < 0 ? -d : d;
    mag = (mag * longint'(Ln2Q30) + (64'd1 << 29)) >> 30;
    ln_q24 = d < 0 ? -longint'(mag) : longint'(mag);
    t0ck = cfg_nomt + ZeroCCentiK;
    num = 100 * longint'(cfg_beta) * t0ck * (longint'(1) << FracBits);
    den = 100 * longint'(cfg_beta) * (longint'(1) << FracBits) + t0ck * ln_q24;
    if (den <= 0) return 16'sd32767;
    return clamp16((num + den / 2) / den - ZeroCCentiK);
  endfunction

  function automatic reading_t predict_reading(sample_t s);
    reading_t o;
    longint unsigned v, r;
    longint diff;
    v = s.volt;
    o.stat = STATUS_INVALID;
    o.temp = '0;
    o.res = '0;
    if (!s.cal || v == 0 || v >= cfg_supply) return o;
    r = (cfg_fixed * v + (cfg_supply - v) / 2) / (cfg_supply - v);
    if (r > 64'hFFFFFF) r = 64'hFFFFFF;
    o.res = r[23:0];
    o.temp = beta_temp(v);
    diff = longint'(o.temp) - longint'(last_temp);
    if (diff < 0) diff = -diff;
    if (!reported || diff > longint'(cfg_delta)) begin
      o.stat = STATUS_REPORTED;
      last_temp = o.temp;
      reported = 1;
    end else begin
      o.stat = STATUS_SMALL;
    end
    return o;
  endfunction

  // acceptance, prediction and result check
  always @(posedge clk) begin
    reading_t e;
    sample_t s;
    in_took = in_valid && !in_stall;
    if (!rst && in_took) begin
      s.volt = voltage_mv;
      s.cal = calibrated;
      readings_q.push_back(predict_reading(s));
    end
    if (!rst && out_valid && !out_stall) begin
      if (readings_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: status %0d temp %0d res %0d",
                                       status, temperature_centi_c, resistance_ohm);
      end else begin
        e = readings_q.pop_front();
        if (e.stat !== status || e.temp !== temperature_centi_c ||
            e.res !== resistance_ohm) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d", e.stat, e.temp,
                     e.res, status, temperature_centi_c, resistance_ohm);
        end
      end
    end
  end

  // sender
  always @(negedge clk) begin
    sample_t s;
    if (!rst && (!in_valid || in_took)) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 0;
      end else if (samples_q.size() > 0 && !hold_tx) begin
        s = samples_q.pop_front();
        voltage_mv <= s.volt;
        calibrated <= s.cal;
        in_valid <= 1;
        tx_gap = idle_on ? pick_gap() : 0;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      out_stall <= 1;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_stall <= 1;
    end else begin
      rx_gap = idle_on ? pick_gap() : 0;
      out_stall <= (rx_gap != 0);
    end
  end

  task automatic reg_write(logic [2:0] idx, longint val);
    @(negedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= val[31:0];
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    case (idx)
      REG_SUPPLY: cfg_supply = val & 64'hFFF;
      REG_FIXED:  cfg_fixed = val & 64'hFFFFF;
      REG_NOMR:   cfg_nomr = val & 64'hFFFFF;
      REG_NOMT:   cfg_nomt = longint'($signed(val[14:0]));
      REG_BETA:   cfg_beta = val & 64'h3FFF;
      REG_DELTA:  cfg_delta = val & 64'h3FFF;
      default: ;
    endcase
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic set_all(longint s, longint f, longint r0, longint t0, longint b,
                         longint dl);
    reg_write(REG_SUPPLY, s);
    reg_write(REG_FIXED, f);
    reg_write(REG_NOMR, r0);
    reg_write(REG_NOMT, t0);
    reg_write(REG_BETA, b);
    reg_write(REG_DELTA, dl);
  endtask

  task automatic add_sample(int v, bit c);
    sample_t s;
    s.volt = v;
    s.cal = c;
    samples_q.push_back(s);
  endtask

  task automatic drain();
    wait (samples_q.size() == 0 && !in_valid && readings_q.size() == 0);
    repeat (1000) @(posedge clk);
  endtask

  task automatic random_phase(int n, int vmax);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0)
        add_sample($urandom_range(0, 4095), $urandom_range(0, 1));
      else
        add_sample($urandom_range(1, vmax), 1);
    end
  endtask

  initial begin
    cfg_supply = 3300; cfg_fixed = 1000; cfg_nomr = 10000;
    cfg_nomt = 2500; cfg_beta = 3950; cfg_delta = 50;
    last_temp = 0;
    reported = 0;
    repeat (5) @(posedge clk);
    rst <= 0;

    // reset settings: invalid samples, edges of the divider, small changes
    add_sample(1650, 0);
    add_sample(0, 1);
    add_sample(3300, 1);
    add_sample(4095, 1);
    add_sample(1650, 1);
    add_sample(1660, 1);
    add_sample(1700, 1);
    add_sample(1, 1);
    add_sample(3299, 1);
    add_sample(3299, 1);
    add_sample(2048, 1);
    add_sample(1024, 1);
    drain();

    // zero fixed resistor gives absolute zero, low ratio overflows denominator
    set_all(4095, 0, 1000000, 15000, 1000, 0);
    add_sample(100, 1);
    add_sample(4094, 1);
    drain();
    reg_write(REG_FIXED, 1);
    add_sample(1, 1);
    add_sample(50, 1);
    add_sample(4094, 1);
    drain();

    // extremes
    set_all(1, 1, 1, -4000, 1000, 0);
    random_phase(30, 4095);
    drain();
    set_all(4095, 1000000, 1000000, 15000, 10000, 10000);
    random_phase(60, 4094);
    drain();
    set_all(4095, 1000000, 1, -4000, 10000, 0);
    random_phase(60, 4094);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      int sup;
      idle_on = (ph != 2);
      sup = $urandom_range(100, 4095);
      set_all(sup, $urandom_range(1, 1000000), $urandom_range(1, 1000000),
              longint'($urandom_range(0, 19000)) - 4000, $urandom_range(1000, 10000),
              $urandom_range(0, 300));
      if (ph == 3) begin
        random_phase(20, sup - 1);
        rx_hold = 2000;
      end
      random_phase(100, sup - 1);
      drain();
    end

    idle_on = 1;
    hold_tx = 1;
    random_phase(20, 3000);
    repeat (200) @(posedge clk);
    hold_tx = 0;
    wait (samples_q.size() == 0 && !in_valid && readings_q.size() == 0);
    repeat (1000) @(posedge clk);

    if (mismatches == 0 && readings_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
